@@ rtl/dxt1_pkg.sv @@
// Shared types and constants for the DXT1 texel sampler.
// Used by dxt1_palette, dxt1_texel_sampler and the testbench; depends on nothing else.
package dxt1_pkg;

    localparam int MAX_TEX_LOG2_DEF = 9;
    localparam int MIN_TEX_LOG2     = 6;
    localparam int CFG_W            = 4;
    localparam logic [CFG_W-1:0] TEX_LOG2_RESET = 4'd9;

    localparam int STORE_AW    = 14;
    localparam int STORE_DEPTH = 1 << STORE_AW;
    localparam int BLOCK_W     = 64;
    localparam int COLOUR_W    = 16;
    localparam int INDEX_W     = 32;
    localparam int COORD_W     = 32;
    localparam int LIGHT_W     = 8;
    localparam int CHAN_W      = 8;
    localparam int RGB_W       = 3 * CHAN_W;
    localparam int IN_DATA_W   = 152;

    localparam logic KIND_LOAD   = 1'b0;
    localparam logic KIND_SAMPLE = 1'b1;

    localparam logic [COLOUR_W-1:0] RED_MASK   = 16'hf800;
    localparam logic [COLOUR_W-1:0] GREEN_MASK = 16'h07e0;
    localparam logic [COLOUR_W-1:0] BLUE_MASK  = 16'h001f;

    localparam logic [3:0] WEIGHT_HI    = 4'd10;
    localparam logic [3:0] WEIGHT_LO    = 4'd6;
    localparam int         WEIGHT_SHIFT = 4;

    localparam logic [1:0] IDX_END_A = 2'd0;
    localparam logic [1:0] IDX_END_B = 2'd1;
    localparam logic [1:0] IDX_MID_A = 2'd2;
    localparam logic [1:0] IDX_MID_B = 2'd3;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } rgb_t;

endpackage

@@ rtl/dxt1_palette.sv @@
// Palette decode for one DXT1 block: expands the end colours and picks a texel.
// Depends on dxt1_pkg.
module dxt1_palette (
    input  logic [dxt1_pkg::BLOCK_W-1:0] blk,
    input  logic [3:0]                   pos,
    output dxt1_pkg::rgb_t               colour
);

    function automatic dxt1_pkg::rgb_t expand(input logic [dxt1_pkg::COLOUR_W-1:0] c);
        dxt1_pkg::rgb_t               e;
        logic [dxt1_pkg::COLOUR_W-1:0] r;
        logic [dxt1_pkg::COLOUR_W-1:0] g;
        logic [dxt1_pkg::COLOUR_W-1:0] b;
        r = (c & dxt1_pkg::RED_MASK) >> 8;
        g = (c & dxt1_pkg::GREEN_MASK) >> 3;
        b = (c & dxt1_pkg::BLUE_MASK) << 3;
        e.red   = r[7:0];
        e.green = g[7:0];
        e.blue  = b[7:0];
        return e;
    endfunction

    function automatic logic [7:0] mix(input logic [7:0] a, input logic [7:0] b);
        logic [11:0] s;
        s = 12'(a) * 12'(dxt1_pkg::WEIGHT_HI) + 12'(b) * 12'(dxt1_pkg::WEIGHT_LO);
        return s[11:dxt1_pkg::WEIGHT_SHIFT];
    endfunction

    function automatic logic [7:0] avg(input logic [7:0] a, input logic [7:0] b);
        logic [8:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[8:1];
    endfunction

    logic [dxt1_pkg::COLOUR_W-1:0] c0;
    logic [dxt1_pkg::COLOUR_W-1:0] c1;
    logic [dxt1_pkg::INDEX_W-1:0]  idx_bits;
    logic [1:0]                    idx;
    dxt1_pkg::rgb_t                e0;
    dxt1_pkg::rgb_t                e1;

    assign c0       = blk[15:0];
    assign c1       = blk[31:16];
    assign idx_bits = blk[63:32];
    assign idx      = idx_bits[{pos, 1'b0} +: 2];
    assign e0       = expand(c0);
    assign e1       = expand(c1);

    always_comb
    begin
        case (idx)
            dxt1_pkg::IDX_END_A:
            begin
                colour = e0;
            end
            dxt1_pkg::IDX_END_B:
            begin
                colour = e1;
            end
            dxt1_pkg::IDX_MID_A:
            begin
                if (c0 > c1)
                begin
                    colour.red   = mix(e0.red, e1.red);
                    colour.green = mix(e0.green, e1.green);
                    colour.blue  = mix(e0.blue, e1.blue);
                end
                else
                begin
                    colour.red   = avg(e0.red, e1.red);
                    colour.green = avg(e0.green, e1.green);
                    colour.blue  = avg(e0.blue, e1.blue);
                end
            end
            default:
            begin
                if (c0 > c1)
                begin
                    colour.red   = mix(e1.red, e0.red);
                    colour.green = mix(e1.green, e0.green);
                    colour.blue  = mix(e1.blue, e0.blue);
                end
                else
                begin
                    colour = '0;
                end
            end
        endcase
    end

endmodule

@@ rtl/dxt1_texel_sampler.sv @@
// Top level of the DXT1 texel sampler: block store, address pipeline and lighting.
// Depends on dxt1_pkg and dxt1_palette.
//
// The sampler takes one beat per clock unless stalled, load or sample alike, and
// a sample's colour passes the block read register and the colour register to
// the output register. A load writes the 16384 x 64-bit block store at the edge
// that takes it, so a sample in the very next beat already sees that block. The
// store is one synchronous memory with one access per cycle, which sets the rate;
// it has no clearing pass, and a block must be loaded before it is sampled. Stages
// stall one by one from the output back, so bubbles fill while a result waits.
module dxt1_texel_sampler #(
    parameter int MAX_TEX_LOG2 = dxt1_pkg::MAX_TEX_LOG2_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [dxt1_pkg::CFG_W-1:0]     cfg_wr_data,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // Fields from bit 0: block_addr, end_colour_a, end_colour_b, texel_indices,
    // u_coord, v_coord, light_level, zero fill.
    input  logic [dxt1_pkg::IN_DATA_W-1:0] s_axis_tdata,
    // Field: kind.
    input  logic                           s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // Field: texel_rgb.
    output logic [dxt1_pkg::RGB_W-1:0]     m_axis_tdata
);

    localparam int BLK_W       = MAX_TEX_LOG2 - 2;
    localparam int ADDR_FULL_W = 2 * BLK_W;

    function automatic logic [7:0] lit(input logic [7:0] ch, input logic [7:0] level);
        logic [15:0] p;
        p = 16'(ch) * 16'(level);
        return p[15:8];
    endfunction

    logic [dxt1_pkg::CFG_W-1:0] tex_size_log2_reg;

    logic [dxt1_pkg::STORE_AW-1:0] in_block_addr;
    logic [dxt1_pkg::COLOUR_W-1:0] in_colour_a;
    logic [dxt1_pkg::COLOUR_W-1:0] in_colour_b;
    logic [dxt1_pkg::INDEX_W-1:0]  in_indices;
    logic [dxt1_pkg::COORD_W-1:0]  in_u;
    logic [dxt1_pkg::COORD_W-1:0]  in_v;
    logic [dxt1_pkg::LIGHT_W-1:0]  in_light;

    logic                          in_accept;
    logic                          load_accept;
    logic                          sample_accept;
    logic [dxt1_pkg::CFG_W-1:0]    size_eff;
    logic [4:0]                    coord_shift;
    logic [dxt1_pkg::COORD_W-1:0]  tu;
    logic [dxt1_pkg::COORD_W-1:0]  tv;
    logic [BLK_W-1:0]              blk_mask;
    logic [BLK_W-1:0]              blk_u;
    logic [BLK_W-1:0]              blk_v;
    logic [ADDR_FULL_W-1:0]        addr_full;
    logic [dxt1_pkg::STORE_AW-1:0] rd_addr;

    logic [dxt1_pkg::BLOCK_W-1:0]  store_mem [dxt1_pkg::STORE_DEPTH];
    logic [dxt1_pkg::BLOCK_W-1:0]  rd_data_reg;

    logic                          v1_reg;
    logic [3:0]                    pos1_reg;
    logic [dxt1_pkg::LIGHT_W-1:0]  light1_reg;
    dxt1_pkg::rgb_t                colour1;

    logic                          v2_reg;
    dxt1_pkg::rgb_t                rgb2_reg;
    logic [dxt1_pkg::LIGHT_W-1:0]  light2_reg;

    logic                          vo_reg;
    logic [dxt1_pkg::RGB_W-1:0]    out_data_reg;

    logic                          adv1;
    logic                          adv2;
    logic                          adv_out;

    assign in_block_addr = s_axis_tdata[13:0];
    assign in_colour_a   = s_axis_tdata[29:14];
    assign in_colour_b   = s_axis_tdata[45:30];
    assign in_indices    = s_axis_tdata[77:46];
    assign in_u          = s_axis_tdata[109:78];
    assign in_v          = s_axis_tdata[141:110];
    assign in_light      = s_axis_tdata[149:142];

    assign adv_out       = vo_reg && m_axis_tready;
    assign adv2          = v2_reg && (!vo_reg || adv_out);
    assign adv1          = v1_reg && (!v2_reg || adv2);
    assign s_axis_tready = !v1_reg || adv1;

    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign load_accept   = in_accept && (s_axis_tuser == dxt1_pkg::KIND_LOAD);
    assign sample_accept = in_accept && (s_axis_tuser == dxt1_pkg::KIND_SAMPLE);

    always_comb
    begin
        if (tex_size_log2_reg < dxt1_pkg::CFG_W'(dxt1_pkg::MIN_TEX_LOG2))
        begin
            size_eff = dxt1_pkg::CFG_W'(dxt1_pkg::MIN_TEX_LOG2);
        end
        else if (tex_size_log2_reg > dxt1_pkg::CFG_W'(MAX_TEX_LOG2))
        begin
            size_eff = dxt1_pkg::CFG_W'(MAX_TEX_LOG2);
        end
        else
        begin
            size_eff = tex_size_log2_reg;
        end
    end

    assign coord_shift = 5'd24 - 5'(size_eff);
    assign tu          = in_u >> coord_shift;
    assign tv          = in_v >> coord_shift;
    assign blk_mask    = (BLK_W'(1) << (size_eff - 4'd2)) - BLK_W'(1);
    assign blk_u       = tu[MAX_TEX_LOG2-1:2] & blk_mask;
    assign blk_v       = tv[MAX_TEX_LOG2-1:2] & blk_mask;
    assign addr_full   = ADDR_FULL_W'(blk_u) | (ADDR_FULL_W'(blk_v) << (size_eff - 4'd2));
    assign rd_addr     = dxt1_pkg::STORE_AW'(addr_full);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tex_size_log2_reg <= dxt1_pkg::TEX_LOG2_RESET;
        end
        else if (cfg_wr_en)
        begin
            tex_size_log2_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_accept)
        begin
            store_mem[in_block_addr] <= {in_indices, in_colour_b, in_colour_a};
        end
        if (sample_accept)
        begin
            rd_data_reg <= store_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else
        begin
            if (sample_accept)
            begin
                v1_reg <= 1'b1;
            end
            else if (adv1)
            begin
                v1_reg <= 1'b0;
            end
            if (adv1)
            begin
                v2_reg <= 1'b1;
            end
            else if (adv2)
            begin
                v2_reg <= 1'b0;
            end
            if (adv2)
            begin
                vo_reg <= 1'b1;
            end
            else if (adv_out)
            begin
                vo_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample_accept)
        begin
            pos1_reg   <= {tv[1:0], tu[1:0]};
            light1_reg <= in_light;
        end
        if (adv1)
        begin
            rgb2_reg   <= colour1;
            light2_reg <= light1_reg;
        end
        if (adv2)
        begin
            out_data_reg <= {lit(rgb2_reg.red, light2_reg),
                             lit(rgb2_reg.green, light2_reg),
                             lit(rgb2_reg.blue, light2_reg)};
        end
    end

    dxt1_palette u_palette (
        .blk    (rd_data_reg),
        .pos    (pos1_reg),
        .colour (colour1)
    );

    assign m_axis_tvalid = vo_reg;
    assign m_axis_tdata  = out_data_reg;

    assert property (@(posedge clk) disable iff (!rst_n) sample_accept |=> v1_reg)
        else $error("Sample beat taken but block read stage is empty.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (v1_reg && !adv1) |=> (v1_reg && $stable(rd_data_reg) && $stable(pos1_reg)))
        else $error("Stalled block read data changed.");

    assert property (@(posedge clk) disable iff (!rst_n) adv2 |=> vo_reg)
        else $error("Lit result lost on its way to the output register.");

    assert property (@(posedge clk) disable iff (!rst_n) !s_axis_tready |-> (v1_reg && v2_reg))
        else $error("Input stalled while the pipeline has room.");

endmodule

@@ verif/dxt1_texel_sampler_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for dxt1_texel_sampler: loads DXT1 blocks, samples them
// and compares every lit texel with a predictor kept in step with the block store.
// Depends on dxt1_pkg and the dxt1_texel_sampler RTL.
module dxt1_texel_sampler_tb;
    import dxt1_pkg::*;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_CYCLES = 8;
    localparam int PHASE_BEATS  = 300;

    typedef struct packed {
        logic                kind;
        logic [STORE_AW-1:0] block_addr;
        logic [COLOUR_W-1:0] colour_a;
        logic [COLOUR_W-1:0] colour_b;
        logic [INDEX_W-1:0]  indices;
        logic [COORD_W-1:0]  u;
        logic [COORD_W-1:0]  v;
        logic [LIGHT_W-1:0]  light;
    } texel_req_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_W-1:0]     cfg_wr_data = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [IN_DATA_W-1:0] s_axis_tdata = '0;
    logic                 s_axis_tuser = 1'b0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [RGB_W-1:0]     m_axis_tdata;

    logic [BLOCK_W-1:0] block_mem [STORE_DEPTH];
    bit                 block_loaded [STORE_DEPTH];
    int unsigned        loaded_addrs [$];
    logic [RGB_W-1:0]   expected_texels [$];
    logic [CFG_W-1:0]   size_code_q = TEX_LOG2_RESET;
    logic [RGB_W-1:0]   want_rgb;
    logic               burst_mode = 1'b0;
    int                 ready_hold = 0;
    int                 fail_count = 0;
    int                 cycle_count = 0;

    dxt1_texel_sampler uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic int unsigned texture_log2();
        int unsigned sz;
        sz = size_code_q;
        if (sz < MIN_TEX_LOG2)
            sz = MIN_TEX_LOG2;
        if (sz > MAX_TEX_LOG2_DEF)
            sz = MAX_TEX_LOG2_DEF;
        return sz;
    endfunction

    function automatic logic [RGB_W-1:0] predict_texel(logic [COORD_W-1:0] u,
                                                       logic [COORD_W-1:0] v,
                                                       logic [LIGHT_W-1:0] level);
        int unsigned sz, sh, bmask, tu, tv, pos, k;
        logic [STORE_AW-1:0] addr;
        logic [BLOCK_W-1:0] blk;
        logic [COLOUR_W-1:0] c0, c1;
        logic [1:0] idx;
        int unsigned e0 [3];
        int unsigned e1 [3];
        int unsigned mix;
        logic [RGB_W-1:0] rgb;
        sz = texture_log2();
        sh = 24 - sz;
        tu = u >> sh;
        tv = v >> sh;
        bmask = (1 << (sz - 2)) - 1;
        addr = STORE_AW'(((tu >> 2) & bmask) + (((tv >> 2) & bmask) << (sz - 2)));
        blk = block_mem[addr];
        c0 = blk[15:0];
        c1 = blk[31:16];
        pos = ((tu & 3) + ((tv & 3) << 2)) * 2;
        idx = 2'(blk >> (32 + pos));
        e0[0] = (c0 & RED_MASK) >> 8;
        e0[1] = (c0 & GREEN_MASK) >> 3;
        e0[2] = (c0 & BLUE_MASK) << 3;
        e1[0] = (c1 & RED_MASK) >> 8;
        e1[1] = (c1 & GREEN_MASK) >> 3;
        e1[2] = (c1 & BLUE_MASK) << 3;
        for (k = 0; k < 3; k++)
        begin
            case (idx)
                IDX_END_A: mix = e0[k];
                IDX_END_B: mix = e1[k];
                IDX_MID_A: mix = (c0 > c1) ?
                                 (e0[k] * WEIGHT_HI + e1[k] * WEIGHT_LO) >> WEIGHT_SHIFT :
                                 (e0[k] + e1[k]) >> 1;
                default:   mix = (c0 > c1) ?
                                 (e0[k] * WEIGHT_LO + e1[k] * WEIGHT_HI) >> WEIGHT_SHIFT :
                                 0;
            endcase
            rgb[8 * (2 - k) +: 8] = 8'((mix * level) >> 8);
        end
        return rgb;
    endfunction

    function automatic texel_req_t random_req();
        texel_req_t req;
        req.kind       = 1'($urandom);
        req.block_addr = STORE_AW'($urandom);
        req.colour_a   = COLOUR_W'($urandom);
        req.colour_b   = COLOUR_W'($urandom);
        req.indices    = $urandom;
        req.u          = $urandom;
        req.v          = $urandom;
        req.light      = LIGHT_W'($urandom);
        return req;
    endfunction

    function automatic int pick_gap();
        int r;
        if (burst_mode)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(4, 20);
    endfunction

    // Sends one beat, waits for it to be taken and updates the predictor.
    task automatic send_beat(input texel_req_t req);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= req.kind;
        s_axis_tdata  <= {2'b00, req.light, req.v, req.u, req.indices,
                          req.colour_b, req.colour_a, req.block_addr};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        if (req.kind == KIND_LOAD)
        begin
            block_mem[req.block_addr]    = {req.indices, req.colour_b, req.colour_a};
            block_loaded[req.block_addr] = 1'b1;
            loaded_addrs.push_back(req.block_addr);
        end
        else
        begin
            expected_texels.push_back(predict_texel(req.u, req.v, req.light));
        end
    endtask

    task automatic load_block(input int unsigned addr, input logic [COLOUR_W-1:0] ca,
                              input logic [COLOUR_W-1:0] cb, input logic [INDEX_W-1:0] ix);
        texel_req_t req;
        req            = random_req();
        req.kind       = KIND_LOAD;
        req.block_addr = STORE_AW'(addr);
        req.colour_a   = ca;
        req.colour_b   = cb;
        req.indices    = ix;
        send_beat(req);
    endtask

    task automatic load_random_block(input int unsigned addr);
        logic [COLOUR_W-1:0] ca, cb;
        ca = COLOUR_W'($urandom);
        cb = COLOUR_W'($urandom);
        if ($urandom_range(0, 9) == 0)
            cb = ca;
        load_block(addr, ca, cb, $urandom);
    endtask

    // Samples texel (tx, ty) of a block; the block is loaded first if it never was.
    task automatic sample_at(input int unsigned addr, input logic [1:0] tx,
                             input logic [1:0] ty, input logic [LIGHT_W-1:0] light);
        texel_req_t req;
        int unsigned sz, sh, bmask, keep;
        sz    = texture_log2();
        sh    = 24 - sz;
        bmask = (1 << (sz - 2)) - 1;
        addr  = addr & ((1 << (2 * sz - 4)) - 1);
        if (!block_loaded[addr])
            load_random_block(addr);
        req       = random_req();
        req.kind  = KIND_SAMPLE;
        req.light = light;
        keep      = ~((bmask << (sh + 2)) | (32'h3 << sh));
        req.u = (req.u & keep) | ((addr & bmask) << (sh + 2)) | (32'(tx) << sh);
        req.v = (req.v & keep) | ((addr >> (sz - 2)) << (sh + 2)) | (32'(ty) << sh);
        send_beat(req);
    endtask

    task automatic set_texture_size(input logic [CFG_W-1:0] size_code);
        s_axis_tvalid <= 1'b0;
        while (expected_texels.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= size_code;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        size_code_q = size_code;
    endtask

    task automatic test_palette_modes();
        int x;
        load_block(0, 16'hffff, 16'h0000, 32'he4e4e4e4);
        for (x = 0; x < 4; x++)
            sample_at(0, 2'(x), 2'(x), 8'hff);
        load_block(STORE_DEPTH - 1, 16'h0000, 16'hffff, 32'he4e4e4e4);
        sample_at(STORE_DEPTH - 1, 2'd2, 2'd1, 8'hff);
        sample_at(STORE_DEPTH - 1, 2'd3, 2'd3, 8'hff);
        sample_at(STORE_DEPTH - 1, 2'd0, 2'd2, 8'h00);
        load_block(5, 16'h7bef, 16'h7bef, 32'hffffaaaa);
        sample_at(5, 2'd0, 2'd0, 8'h80);
        sample_at(5, 2'd3, 2'd3, 8'h80);
        load_block(6, 16'hf81f, 16'h07e0, 32'h55aaff00);
        sample_at(6, 2'd1, 2'd2, 8'hff);
        sample_at(6, 2'd2, 2'd3, 8'h01);
    endtask

    task automatic test_load_then_sample();
        burst_mode <= 1'b1;
        load_random_block(77);
        sample_at(77, 2'($urandom), 2'($urandom), 8'hff);
        load_block(77, 16'h8410, 16'h0841, 32'hffffffff);
        sample_at(77, 2'd1, 2'd1, 8'hff);
        sample_at(77, 2'd2, 2'd0, 8'hc0);
        burst_mode <= 1'b0;
    endtask

    task automatic test_size_register();
        set_texture_size(4'd6);
        sample_at(0, 2'd3, 2'd0, 8'hff);
        sample_at(255, 2'd1, 2'd3, 8'hff);
        set_texture_size(4'd15);
        sample_at(STORE_DEPTH - 1, 2'd3, 2'd3, 8'hff);
        set_texture_size(4'd0);
        sample_at(255, 2'd0, 2'd1, 8'h7f);
        set_texture_size(4'd9);
        sample_at(STORE_DEPTH - 1, 2'd2, 2'd2, 8'hff);
    endtask

    task automatic test_random_traffic();
        logic [CFG_W-1:0] phase_codes [5];
        texel_req_t req;
        int phase, i, r;
        int unsigned addr;
        phase_codes[0] = 4'd6;
        phase_codes[1] = 4'd9;
        phase_codes[2] = CFG_W'($urandom_range(0, 15));
        phase_codes[3] = CFG_W'($urandom_range(6, 9));
        phase_codes[4] = CFG_W'($urandom_range(0, 15));
        for (phase = 0; phase < 5; phase++)
        begin
            set_texture_size(phase_codes[phase]);
            for (i = 0; i < PHASE_BEATS; i++)
            begin
                if (i % 100 == 0)
                    burst_mode <= ($urandom_range(0, 3) == 0);
                r = $urandom_range(0, 99);
                if (r < 25)
                begin
                    req      = random_req();
                    req.kind = KIND_LOAD;
                    send_beat(req);
                end
                else if (r < 35)
                begin
                    addr = $urandom_range(0, STORE_DEPTH - 1)
                           & ((1 << (2 * texture_log2() - 4)) - 1);
                    load_random_block(addr);
                    sample_at(addr, 2'($urandom), 2'($urandom), LIGHT_W'($urandom));
                end
                else if (r < 70 && loaded_addrs.size() > 0)
                begin
                    addr = loaded_addrs[$urandom_range(0, loaded_addrs.size() - 1)];
                    sample_at(addr, 2'($urandom), 2'($urandom), LIGHT_W'($urandom));
                end
                else
                begin
                    sample_at($urandom_range(0, STORE_DEPTH - 1), 2'($urandom), 2'($urandom),
                              LIGHT_W'($urandom));
                end
            end
        end
        burst_mode <= 1'b0;
    endtask

    always @(posedge clk)
    begin
        if (burst_mode)
        begin
            m_axis_tready <= 1'b1;
        end
        else if (ready_hold > 0)
        begin
            m_axis_tready <= 1'b0;
            ready_hold    <= ready_hold - 1;
        end
        else
        begin
            m_axis_tready <= ($urandom_range(0, 99) < 75);
            if ($urandom_range(0, 99) < 4)
                ready_hold <= $urandom_range(4, 20);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_texels.size() == 0)
            begin
                fail_count++;
                if (fail_count <= 10)
                    $display("Unexpected result beat: texel_rgb %06h", m_axis_tdata);
            end
            else
            begin
                want_rgb = expected_texels.pop_front();
                if (m_axis_tdata !== want_rgb)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("Mismatch on texel_rgb: expected %06h, actual %06h",
                                 want_rgb, m_axis_tdata);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_palette_modes();
        test_load_then_sample();
        test_size_register();
        test_random_traffic();
        s_axis_tvalid <= 1'b0;
        while (expected_texels.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
